// ===== hdl/bb3_pkg.sv =====
`timescale 1ns / 1ps
package bb3_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_W = 11;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // Window rows/cols in use plus tags for one result
    typedef struct packed {
        logic [71:0] col0;   // top, mid, bottom pixels of left column
        logic [71:0] col1;
        logic [71:0] col2;
        logic        skip_top;
        logic        skip_left;
        logic        skip_right;
        logic        skip_bottom;
        logic [9:0]  row;
        logic [9:0]  col;
        logic        last;
    } t_job;

    // Rounded mean, half up, by multiplication with a reciprocal (a shift for n = 4).
    // n is 9, 6 or 4; sum is at most 9*255.
    function automatic logic [7:0] mean(input logic [11:0] sum, input logic [1:0] sel);
        logic [13:0] num;
        logic [27:0] prod;
        logic [7:0]  q;
        num  = {1'b0, sum, 1'b0};
        prod = '0;
        q    = '0;
        unique case (sel)
            2'd0: begin
                // (2s+9)/18
                prod = 28'(14'(num + 14'd9) * 14'd7282);
                q = prod[24:17];
            end
            2'd1: begin
                // (2s+6)/12
                prod = 28'(14'(num + 14'd6) * 14'd10923);
                q = prod[24:17];
            end
            default: begin
                // (2s+4)/8
                prod = 28'(num + 14'd4);
                q = prod[10:3];
            end
        endcase
        return q;
    endfunction
endpackage

// ===== hdl/bb3_front.sv =====
`timescale 1ns / 1ps
// Front end: line buffers, window, position tracking, release schedule.
module bb3_front #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [23:0]             i_pix,
    output logic                    o_job_valid,
    output bb3_pkg::t_job           o_job,
    input  logic                    i_job_ready
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1;

    logic [bb3_pkg::CFG_W-1:0] r_w_cfg, r_h_cfg;
    logic [PW-1:0] eff_w, eff_h;
    logic [PW-1:0] r_row, r_col;

    logic [23:0] r_old [MAX_WIDTH];
    logic [23:0] r_new [MAX_WIDTH];
    logic [23:0] r_rd_old, r_rd_new;
    logic [23:0] r_win [9];

    // Stage 1 holds accepted pixel while lines are read
    logic          r_s1_v;
    logic          r_s1_wr;
    logic [23:0]   r_s1_pix;
    logic [AW-1:0] r_s1_idx;
    logic [PW-1:0] r_s1_row, r_s1_col;
    logic          r_s1_fin, r_s1_end;

    // Emission phase: up to 4 jobs from one window
    logic [1:0]    r_ph;
    logic          r_s2_v;
    logic [PW-1:0] r_s2_row, r_s2_col;
    logic          r_s2_fin, r_s2_end;
    logic [1:0]    n_ph;
    logic          s2_done, s2_adv;

    wire [AW-1:0] r_s1_idx_n = AW'(r_col);

    always_comb begin
        eff_w = PW'(r_w_cfg);
        eff_h = PW'(r_h_cfg);
        if (r_w_cfg < 11'd2) eff_w = PW'(2);
        else if (32'(r_w_cfg) > MAX_WIDTH) eff_w = PW'(MAX_WIDTH);
        if (r_h_cfg < 11'd2) eff_h = PW'(2);
        else if (32'(r_h_cfg) > MAX_HEIGHT) eff_h = PW'(MAX_HEIGHT);
    end

    // Sequence of jobs: phases 0..3 = up, final, up-right, final-right
    logic ph_ok [4];
    always_comb begin
        ph_ok[0] = 1'b1;
        ph_ok[1] = r_s2_fin;
        ph_ok[2] = r_s2_end;
        ph_ok[3] = r_s2_fin && r_s2_end;
    end
    always_comb begin
        n_ph = r_ph;
        s2_done = 1'b1;
        priority if (r_ph == 2'd0 && ph_ok[1]) n_ph = 2'd1;
        else if (r_ph <= 2'd1 && ph_ok[2]) n_ph = 2'd2;
        else if (r_ph <= 2'd2 && ph_ok[3]) n_ph = 2'd3;
        else n_ph = r_ph;
        if (n_ph != r_ph) s2_done = 1'b0;
    end
    assign s2_adv = r_s2_v && (!o_job_valid || i_job_ready);
    wire s2_free = !r_s2_v || (s2_adv && s2_done);
    wire s1_emit = r_s1_v && r_s1_row != '0 && r_s1_col != '0;
    // the window may only shift once stage 2 is through with it
    wire s1_go   = r_s1_v && s2_free;
    assign o_ready = !r_s1_v || s1_go;
    wire acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_old <= r_old[r_s1_idx_n];
            r_rd_new <= r_new[r_s1_idx_n];
            r_new[r_s1_idx_n] <= i_pix;
        end
        // newer line entry moves to the older line in the cycle after it is read
        if (r_s1_wr) r_old[r_s1_idx] <= r_rd_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cfg <= 11'd640; r_h_cfg <= 11'd480;
            r_row <= '0; r_col <= '0;
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_ph <= '0;
            r_s1_wr <= 1'b0;
            o_job_valid <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bb3_pkg::REG_WIDTH) r_w_cfg <= i_cfg_data;
                else r_h_cfg <= i_cfg_data;
                r_row <= '0; r_col <= '0;
            end else if (acc) begin
                if (r_col + 1'b1 >= eff_w) begin
                    r_col <= '0;
                    r_row <= (r_row + 1'b1 >= eff_h) ? '0 : r_row + 1'b1;
                end else r_col <= r_col + 1'b1;
            end
            r_s1_wr <= acc;
            if (acc) begin
                r_s1_pix <= i_pix; r_s1_idx <= r_s1_idx_n;
                r_s1_row <= r_row; r_s1_col <= r_col;
                r_s1_fin <= (r_row == eff_h - 1'b1);
                r_s1_end <= (r_col == eff_w - 1'b1);
            end
            if (acc) r_s1_v <= 1'b1;
            else if (s1_go) r_s1_v <= 1'b0;
            // window shift when stage 1 retires
            if (s1_go) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3]   <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= r_rd_old; r_win[5] <= r_rd_new; r_win[8] <= r_s1_pix;
            end
            if (s2_adv) o_job_valid <= 1'b1;
            else if (i_job_ready) o_job_valid <= 1'b0;
            if (s2_adv) r_ph <= s2_done ? 2'd0 : n_ph;
            if (s1_go && s1_emit) begin
                r_s2_v <= 1'b1;
                r_s2_row <= r_s1_row; r_s2_col <= r_s1_col;
                r_s2_fin <= r_s1_fin; r_s2_end <= r_s1_end;
            end else if (s2_adv && s2_done) r_s2_v <= 1'b0;
        end
    end

    // Job builder, right side uses shifted window for end-of-row jobs
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            if (r_ph[1]) begin
                o_job.col0 <= {r_win[1], r_win[4], r_win[7]};
                o_job.col1 <= {r_win[2], r_win[5], r_win[8]};
                o_job.col2 <= '0;
                o_job.skip_right <= 1'b1; o_job.skip_left <= 1'b0;
                o_job.col <= 10'(r_s2_col);
            end else begin
                o_job.col0 <= {r_win[0], r_win[3], r_win[6]};
                o_job.col1 <= {r_win[1], r_win[4], r_win[7]};
                o_job.col2 <= {r_win[2], r_win[5], r_win[8]};
                o_job.skip_right <= 1'b0;
                o_job.skip_left <= (r_s2_col == PW'(1));
                o_job.col <= 10'(r_s2_col - 1'b1);
            end
            o_job.skip_top <= r_ph[0] || (r_s2_row == PW'(1));
            o_job.skip_bottom <= 1'b0;
            o_job.row <= r_ph[0] ? 10'(r_s2_row) : 10'(r_s2_row - 1'b1);
            o_job.last <= s2_done;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_valid && !i_job_ready |=> o_job_valid && $stable(o_job))
        else $error("job dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_adv |-> r_s2_v) else $error("advance without window");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && !r_s2_fin |-> r_ph != 2'd1 && r_ph != 2'd3)
        else $error("final-row phase outside final row");
endmodule

// ===== hdl/bb3_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module bb3_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bb3_pkg::t_job i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bb3_pkg::t_job o_data
);
    bb3_pkg::t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    wire wr = i_valid && o_ready;
    wire rd = o_valid && i_ready;
    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ===== hdl/bb3_back.sv =====
`timescale 1ns / 1ps
// Back end: sums the live window cells, divides, registers the result.
module bb3_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bb3_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [23:0]   o_pix,
    output logic [9:0]    o_row,
    output logic [9:0]    o_col,
    output logic          o_last
);
    // sum stage
    logic         r_v;
    logic [35:0]  r_sum;
    logic [1:0]   r_sel;
    logic [20:0]  r_tag;
    logic [35:0]  n_sum;
    wire adv2 = !o_valid || i_ready;
    wire adv1 = !r_v || adv2;
    assign o_ready = adv1;

    always_comb begin
        logic [71:0] cols [3];
        logic use_c [3];
        logic use_r [3];
        cols[0] = i_job.col0; cols[1] = i_job.col1; cols[2] = i_job.col2;
        use_c[0] = !i_job.skip_left; use_c[1] = 1'b1; use_c[2] = !i_job.skip_right;
        use_r[0] = !i_job.skip_top; use_r[1] = 1'b1; use_r[2] = !i_job.skip_bottom;
        n_sum = '0;
        for (int ch = 0; ch < 3; ch++)
            for (int c = 0; c < 3; c++)
                for (int r = 0; r < 3; r++)
                    if (use_c[c] && use_r[r])
                        n_sum[ch*12 +: 12] = n_sum[ch*12 +: 12]
                            + 12'(cols[c][(2-r)*24 + ch*8 +: 8]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0; o_valid <= 1'b0;
        end else begin
            if (adv1) r_v <= i_valid;
            if (adv2) o_valid <= r_v;
        end
        if (adv1 && i_valid) begin
            r_sum <= n_sum;
            // 3 columns and 3 rows -> 9, one short -> 6, both short -> 4
            r_sel <= (i_job.skip_top || i_job.skip_left || i_job.skip_right)
                   ? ((i_job.skip_top && (i_job.skip_left || i_job.skip_right))
                      ? 2'd2 : 2'd1) : 2'd0;
            r_tag <= {i_job.row, i_job.col, i_job.last};
        end
        if (adv2 && r_v) begin
            for (int ch = 0; ch < 3; ch++)
                o_pix[ch*8 +: 8] <= bb3_pkg::mean(r_sum[ch*12 +: 12], r_sel);
            {o_row, o_col, o_last} <= r_tag;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> r_sel != 2'd3) else $error("bad divisor select");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v && !adv2 |=> r_v && $stable(r_sum)) else $error("sum overwritten");
endmodule

// ===== hdl/box_blur_3x3_edge_aware_core.sv =====
`timescale 1ns / 1ps
// 3x3 edge-aware box blur over RGB raster pixels. Each result is the rounded
// (half up) mean of the in-frame neighbours and carries its row and column.
// A pixel past the first row and column, in a normal row, releases the pixel up-left
// (plus the last column at row end); a final-row pixel releases two (four at row end).
// The front issues one result per cycle from its window while the queue to the back
// end has room, so a pixel that releases several results keeps the window from
// shifting until its last result has gone out; this is set by the single job builder
// feeding the divider pipeline. Line buffers are not cleared after reset. Config
// writes restart the frame.
module box_blur_3x3_edge_aware_core #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // in_red, in_green, in_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // out_red, out_green, out_blue, out_row, out_col, 4'b0
    output logic        m_axis_tlast
);
    logic f_v, f_r, q_v, q_r;
    bb3_pkg::t_job f_job, q_job;
    logic [23:0] pix;
    logic [9:0] row, col;

    bb3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_pix({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
        .o_job_valid(f_v), .o_job(f_job), .i_job_ready(f_r));

    bb3_fifo u_fifo (.i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_data(f_job),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_job));

    bb3_back u_back (.i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_job(q_job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_pix(pix),
        .o_row(row), .o_col(col), .o_last(m_axis_tlast));

    assign m_axis_tdata = {4'b0, col, row, pix[7:0], pix[15:8], pix[23:16]};
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

    localparam int CLK_HALF   = 4;
    localparam int IDLE_PCT   = 29;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_blur_px;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = '0;
    logic [10:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // red, green, blue from the lowest bit
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // red, green, blue, row, col, pad from the lowest bit
    logic        m_axis_tlast;

    box_blur_3x3_edge_aware_core dut (.*);

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Shadow of the block state
    logic [23:0] line_old [0:1023];
    logic [23:0] line_new [0:1023];
    logic [23:0] win [0:2][0:2];
    int unsigned cur_row, cur_col;
    int unsigned img_w = 640, img_h = 480;

    t_blur_px blur_queue[$];
    int errors = 0;
    int cycles = 0;
    bit idle_en = 1'b1;
    bit hold_sink = 1'b0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (row %0d col %0d)", what, got, want,
                 blur_queue.size() ? blur_queue[0].row : 0,
                 blur_queue.size() ? blur_queue[0].col : 0);
        errors++;
    endtask

    function automatic int clamp_dim(input int unsigned v);
        if (v < 2) return 2;
        if (v > 1024) return 1024;
        return v;
    endfunction

    // Rounded mean of window rows r0..2 and columns c0..2 at one position
    function automatic t_blur_px window_mean(input int r0, input int c0,
                                             input int unsigned row, input int unsigned col);
        t_blur_px px;
        int n, ch, i, j, sum;
        logic [7:0] m [0:2];
        n = (3 - r0) * (3 - c0);
        for (ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (i = r0; i < 3; i++)
                for (j = c0; j < 3; j++)
                    sum += (win[i][j] >> (16 - 8 * ch)) & 8'hFF;
            m[ch] = 8'((2 * sum + n) / (2 * n));
        end
        px.red = m[0]; px.green = m[1]; px.blue = m[2];
        px.row = 10'(row); px.col = 10'(col); px.last = 1'b0;
        return px;
    endfunction

    function automatic void blur_predict(input logic [23:0] pix);
        int unsigned w, h, r, c;
        int top, left, i, n0;
        bit fin;
        w = clamp_dim(img_w); h = clamp_dim(img_h);
        r = cur_row; c = cur_col;
        fin = (r == h - 1);
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_old[c];
        win[1][2] = line_new[c];
        win[2][2] = pix;
        line_old[c] = line_new[c];
        line_new[c] = pix;
        n0 = blur_queue.size();
        if (r >= 1 && c >= 1) begin
            top = (r > 1) ? 0 : 1;
            left = (c > 1) ? 0 : 1;
            blur_queue.push_back(window_mean(top, left, r - 1, c - 1));
            if (fin) blur_queue.push_back(window_mean(1, left, r, c - 1));
            if (c == w - 1) begin
                blur_queue.push_back(window_mean(top, 1, r - 1, c));
                if (fin) blur_queue.push_back(window_mean(1, 1, r, c));
            end
        end
        if (blur_queue.size() > n0) blur_queue[$].last = 1'b1;
        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
    endfunction

    // Result checker and sink stall
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (blur_queue.size() == 0) begin
                $display("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata[7:0] != blur_queue[0].red)
                    report("red", m_axis_tdata[7:0], blur_queue[0].red);
                if (m_axis_tdata[15:8] != blur_queue[0].green)
                    report("green", m_axis_tdata[15:8], blur_queue[0].green);
                if (m_axis_tdata[23:16] != blur_queue[0].blue)
                    report("blue", m_axis_tdata[23:16], blur_queue[0].blue);
                if (m_axis_tdata[33:24] != blur_queue[0].row)
                    report("row", m_axis_tdata[33:24], blur_queue[0].row);
                if (m_axis_tdata[43:34] != blur_queue[0].col)
                    report("col", m_axis_tdata[43:34], blur_queue[0].col);
                if (m_axis_tlast != blur_queue[0].last)
                    report("last", m_axis_tlast, blur_queue[0].last);
                void'(blur_queue.pop_front());
            end
        end
        m_axis_tready <= !hold_sink && (!idle_en || $urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Valid stays high after a transaction unless the next one idles first
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, g, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        blur_predict({r, g, b});
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (blur_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bb3_pkg::REG_WIDTH) img_w = val; else img_h = val;
        cur_row = 0; cur_col = 0;
    endtask

    task automatic set_frame(input int w, input int h);
        write_reg(bb3_pkg::REG_WIDTH, 11'(w));
        write_reg(bb3_pkg::REG_HEIGHT, 11'(h));
    endtask

    task automatic send_frames(input int nframes);
        int i, total;
        total = nframes * clamp_dim(img_w) * clamp_dim(img_h);
        for (i = 0; i < total; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Corners, edges and channel extremes on the smallest frames
    task automatic test_directed();
        int i;
        set_frame(2, 2);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h01);
        set_frame(3, 3);
        for (i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, 8'(i * 29), (i == 4) ? 8'hFF : 8'h00);
        // out-of-range registers clamp to 2
        set_frame(0, 1);
        for (i = 0; i < 4; i++) send_pixel(8'hFF, 8'h80, 8'h7F);
    endtask

    // Random frames of several shapes
    task automatic test_random_frames();
        set_frame(5, 4);  send_frames(2);
        set_frame(2, 9);  send_frames(1);
        set_frame(9, 2);  send_frames(1);
        set_frame(7, 6);  send_frames(1);
    endtask

    // Oversize height clamps (first rows only), then a wide two-row frame
    task automatic test_wide();
        int i;
        set_frame(2, 2047);
        for (i = 0; i < 20; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        set_frame(36, 2);
        send_frames(1);
    endtask

    // Restart mid-frame, then two frames with no idling
    task automatic test_restart();
        int i;
        set_frame(6, 5);
        for (i = 0; i < 14; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        write_reg(bb3_pkg::REG_HEIGHT, 11'd3);
        idle_en = 1'b0;
        send_frames(2);
        idle_en = 1'b1;
    endtask

    // Sink holds off long enough for the block to back up
    task automatic test_backpressure();
        int i;
        set_frame(4, 3);
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (i = 0; i < 24; i++) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        join
        wait_drained();
        send_frames(1);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur_row = 0; cur_col = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        test_directed();
        test_random_frames();
        test_wide();
        test_restart();
        test_backpressure();
        wait_drained();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== box_blur_3x3_edge_aware_core.f =====
hdl/bb3_pkg.sv
hdl/bb3_front.sv
hdl/bb3_fifo.sv
hdl/bb3_back.sv
hdl/box_blur_3x3_edge_aware_core.sv
test/testbench.sv
